### rtl/tccc_pkg.sv
// Shared types, register codes and constants for the text console cursor control block.
// Used by every module under rtl; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tccc_pkg;

   // default module parameters
   localparam int DEF_MAX_COLS = 256;
   localparam int DEF_MAX_ROWS = 128;
   localparam int DEF_TAB_STOP = 8;
   localparam int DEF_GLYPH_W  = 8;
   localparam int DEF_GLYPH_H  = 8;

   // output queue depth; an item writes at most two words
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // character codes
   localparam logic [7:0] CODE_BACKSPACE = 8'd8;
   localparam logic [7:0] CODE_TAB       = 8'd9;
   localparam logic [7:0] CODE_NEWLINE   = 8'd10;
   localparam logic [7:0] CODE_SPACE     = 8'd32;
   localparam logic [7:0] CODE_QUESTION  = 8'd63;

   // request kinds
   localparam logic REQ_PUT_CHAR = 1'b0;
   localparam logic REQ_SET_POS  = 1'b1;

   // command codes
   localparam logic CMD_DRAW   = 1'b0;
   localparam logic CMD_SCROLL = 1'b1;

   // register map
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TEXT_COLS   = 3'd0,
      CSR_TEXT_ROWS   = 3'd1,
      CSR_LINE_PIXELS = 3'd2,
      CSR_FIRST_GLYPH = 3'd3,
      CSR_LAST_GLYPH  = 3'd4
   } csr_index_type;

   localparam logic [8:0]  RST_TEXT_COLS   = 9'd80;
   localparam logic [7:0]  RST_TEXT_ROWS   = 8'd30;
   localparam logic [12:0] RST_LINE_PIXELS = 13'd640;
   localparam logic [7:0]  RST_FIRST_GLYPH = 8'd32;
   localparam logic [7:0]  RST_LAST_GLYPH  = 8'd127;

   typedef struct packed {
      logic [8:0]  text_cols;
      logic [7:0]  text_rows;
      logic [12:0] line_pixels;
      logic [7:0]  first_glyph;
      logic [7:0]  last_glyph;
   } csr_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] char_code;
      logic [7:0] col_request;
      logic [7:0] row_request;
   } req_word_type;

   typedef struct packed {
      logic        command;
      logic [7:0]  cell_col;
      logic [6:0]  cell_row;
      logic [7:0]  glyph_index;
      logic [23:0] pixel_offset;
      logic        last;
   } rsp_word_type;

   // words produced by one item: optional draw, then optional scroll
   typedef struct packed {
      logic         draw_vld;
      logic         scroll_vld;
      rsp_word_type draw_word;
   } step_result_type;

   typedef logic [255:0][8:0] tab_table_type;

   // next tab stop for every column, built by counting through the stops
   function automatic tab_table_type tab_table(int stop);
      tab_table_type t;
      int            base;
      int            phase;
      base  = 0;
      phase = 0;
      for (int c = 0; c < 256; c++) begin
         t[c] = 9'(base + stop);
         phase++;
         if (phase == stop) begin
            phase = 0;
            base  = base + stop;
         end
      end
      return t;
   endfunction

endpackage

`default_nettype wire

### rtl/tccc_cursor.sv
// Cursor state and the per-item update: control codes, wrap, clamp, glyph and pixel offset.
// Depends on tccc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tccc_cursor #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 128,
   parameter int TAB_STOP = 8,
   parameter int GLYPH_W  = 8,
   parameter int GLYPH_H  = 8
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      step,
   input  tccc_pkg::req_word_type   req_word,
   input  tccc_pkg::csr_type        csr,
   output tccc_pkg::step_result_type result
);
   import tccc_pkg::*;

   localparam tab_table_type TAB_NEXT  = tab_table(TAB_STOP);
   localparam int            ROW_SCALE = 2 * GLYPH_H;

   logic [7:0]  cursor_col_ff, cursor_col_in;
   logic [6:0]  cursor_row_ff, cursor_row_in;

   logic [8:0]  cols;
   logic [7:0]  rows;
   logic [7:0]  col0;
   logic [6:0]  row0;
   logic [7:0]  set_col;
   logic [6:0]  set_row;
   logic        row_last;
   logic [6:0]  nl_row;
   logic        col_wrap;
   logic [8:0]  tab_col;
   logic        tab_wrap;
   logic        newline;
   logic        draw;
   logic        scroll;
   logic [7:0]  draw_col;
   logic [6:0]  draw_row;
   logic [7:0]  draw_char;
   logic [7:0]  sub_char;
   logic [19:0] row_lp;
   logic [31:0] offset;

   // clamp the grid size into range
   always_comb begin
      cols = csr.text_cols;
      if (csr.text_cols > 9'(MAX_COLS)) cols = 9'(MAX_COLS);
      if (csr.text_cols == 9'd0) cols = 9'd1;
      rows = csr.text_rows;
      if (csr.text_rows > 8'(MAX_ROWS)) rows = 8'(MAX_ROWS);
      if (csr.text_rows == 8'd0) rows = 8'd1;
   end

   // pull the cursor back into the grid and precompute moves
   assign col0 = ({1'b0, cursor_col_ff} >= cols) ? 8'(cols - 9'd1) : cursor_col_ff;
   assign row0 = ({1'b0, cursor_row_ff} >= rows) ? 7'(rows - 8'd1) : cursor_row_ff;
   assign row_last = ({1'b0, row0} + 8'd1) >= rows;
   assign nl_row   = row_last ? 7'(rows - 8'd1) : row0 + 7'd1;
   assign col_wrap = ({1'b0, col0} + 9'd1) >= cols;
   assign tab_col  = TAB_NEXT[col0];
   assign tab_wrap = tab_col >= cols;

   assign set_col = ({1'b0, req_word.col_request} >= cols) ? 8'(cols - 9'd1)
                                                          : req_word.col_request;
   assign set_row = (req_word.row_request >= rows) ? 7'(rows - 8'd1)
                                                   : req_word.row_request[6:0];

   // decode the item into the next cursor and the words to emit
   always_comb begin
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      newline   = 1'b0;
      draw      = 1'b0;
      scroll    = 1'b0;
      draw_col  = col0;
      draw_row  = row0;
      draw_char = req_word.char_code;
      if (req_word.req_type == REQ_SET_POS) begin
         cursor_col_in = set_col;
         cursor_row_in = set_row;
      end else begin
         cursor_col_in = col0;
         cursor_row_in = row0;
         case (req_word.char_code)
            CODE_NEWLINE: begin
               newline = 1'b1;
            end
            CODE_TAB: begin
               if (tab_wrap) newline = 1'b1;
               else cursor_col_in = tab_col[7:0];
            end
            CODE_BACKSPACE: begin
               draw      = 1'b1;
               draw_char = CODE_SPACE;
               if (col0 == 8'd0) begin
                  if (row0 != 7'd0) begin
                     cursor_row_in = row0 - 7'd1;
                     cursor_col_in = 8'(cols - 9'd1);
                  end
               end else begin
                  cursor_col_in = col0 - 8'd1;
               end
               draw_col = cursor_col_in;
               draw_row = cursor_row_in;
            end
            default: begin
               draw = 1'b1;
               if (col_wrap) newline = 1'b1;
               else cursor_col_in = col0 + 8'd1;
            end
         endcase
         if (newline) begin
            cursor_col_in = 8'd0;
            cursor_row_in = nl_row;
            scroll        = row_last;
         end
      end
   end

   // glyph substitution and cell pixel offset
   assign sub_char = (draw_char < csr.first_glyph || draw_char > csr.last_glyph)
                     ? CODE_QUESTION : draw_char;
   assign row_lp = 20'(draw_row) * 20'(csr.line_pixels);
   assign offset = 32'(row_lp) * 32'(ROW_SCALE) + 32'(draw_col) * 32'(GLYPH_W);

   always_comb begin
      result.draw_vld               = draw;
      result.scroll_vld             = scroll;
      result.draw_word.command      = CMD_DRAW;
      result.draw_word.cell_col     = draw_col;
      result.draw_word.cell_row     = draw_row;
      result.draw_word.glyph_index  = sub_char - csr.first_glyph;
      result.draw_word.pixel_offset = offset[23:0];
      result.draw_word.last         = !scroll;
   end

   // advance the cursor when the item is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff <= 8'd0;
         cursor_row_ff <= 7'd0;
      end else if (step) begin
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
      end
   end

endmodule

`default_nettype wire

### rtl/tccc_queue.sv
// Output queue of result words: takes up to two words a cycle while it has room, hands out one unless stalled.
// Depends on tccc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tccc_queue (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push,
   input  tccc_pkg::step_result_type result,
   output logic                      room,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output tccc_pkg::rsp_word_type    rsp_data
);
   import tccc_pkg::*;

   rsp_word_type               slot_ff [QUEUE_DEPTH];
   rsp_word_type               slot_in [QUEUE_DEPTH];
   logic [QUEUE_CNT_W-1:0]     count_ff, count_in;
   logic [QUEUE_CNT_W-1:0]     base;
   logic [QUEUE_CNT_W-1:0]     n_words;
   logic                       pop;
   rsp_word_type               scroll_word;
   rsp_word_type               first_word;

   assign rsp_valid = count_ff != '0;
   assign rsp_data  = slot_ff[0];
   assign pop       = rsp_valid && !rsp_stall;
   assign room      = count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);

   always_comb begin
      scroll_word              = '0;
      scroll_word.command      = CMD_SCROLL;
      scroll_word.last         = 1'b1;
      first_word = result.draw_vld ? result.draw_word : scroll_word;
      n_words    = push ? QUEUE_CNT_W'(result.draw_vld) + QUEUE_CNT_W'(result.scroll_vld)
                        : '0;
   end

   // shift out the head, then drop new words behind what remains
   always_comb begin
      base = count_ff - QUEUE_CNT_W'(pop);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (pop && i < QUEUE_DEPTH - 1) slot_in[i] = slot_ff[(i + 1) % QUEUE_DEPTH];
         else slot_in[i] = slot_ff[i];
         if (n_words != '0 && QUEUE_CNT_W'(i) == base) slot_in[i] = first_word;
         if (n_words == QUEUE_CNT_W'(2) && QUEUE_CNT_W'(i) == base + QUEUE_CNT_W'(1))
            slot_in[i] = scroll_word;
      end
      count_in = base + n_words;
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) slot_ff[i] <= slot_in[i];
   end

`ifndef SYNTHESIS
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2))
      else $error("queue written without room for two words");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
   a_scroll_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.command == CMD_DRAW || rsp_data.last))
      else $error("scroll word not marked last");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (count_ff == QUEUE_CNT_W'(1) && pop && n_words == '0) |=> !rsp_valid)
      else $error("queue still valid after last word taken");
`endif

endmodule

`default_nettype wire

### rtl/text_console_cursor_control_core.sv
// Top level of the text console cursor control block: register file, input register,
// cursor update and output queue. Depends on tccc_pkg, tccc_cursor and tccc_queue.
//
// Usage:
//   req_* carries one request word (put character or set position); it is taken at a
//   clock edge with req_valid high and req_stall low. rsp_* carries draw and scroll
//   words under the same rule. csr_* writes the five registers by index; csr_ready is
//   always high and writes to unknown indexes are dropped.
//   A request is registered, then decoded in one pass through the cursor logic and the
//   row-times-line-width multiplier, and its words land in a four-word output queue.
//   The request's words are written into the queue registers when it is decoded and
//   reach rsp_* in order; a request waits in the input register while the queue lacks
//   room. One request a cycle is accepted for as long as the queue has room for two
//   words, so throughput is one request per cycle while the receiver takes one word a
//   cycle; a request that causes a draw and a scroll gives two words, draw first.
//   When the receiver stalls, the queue fills and req_stall rises once it holds more
//   than two words; no word is lost.
//   Reset (synchronous) empties the queue and input register, puts the cursor at the
//   top left and loads the default grid: 80 by 30 cells, 640 pixel lines, glyphs 32
//   to 127.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_control_core #(
   parameter int MAX_COLS = tccc_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = tccc_pkg::DEF_MAX_ROWS,
   parameter int TAB_STOP = tccc_pkg::DEF_TAB_STOP,
   parameter int GLYPH_W  = tccc_pkg::DEF_GLYPH_W,
   parameter int GLYPH_H  = tccc_pkg::DEF_GLYPH_H
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  tccc_pkg::req_word_type               req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output tccc_pkg::rsp_word_type               rsp_data,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [tccc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [tccc_pkg::CSR_DATA_W-1:0]      csr_data
);
   import tccc_pkg::*;

   csr_type         csr_ff, csr_in;
   req_word_type    req_word_ff;
   logic            req_vld_ff, req_vld_in;
   logic            room;
   logic            step;
   logic            accept;
   step_result_type result;

   assign csr_ready = 1'b1;

   // decode register writes
   always_comb begin
      csr_in = csr_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TEXT_COLS:   csr_in.text_cols   = csr_data[8:0];
            CSR_TEXT_ROWS:   csr_in.text_rows   = csr_data[7:0];
            CSR_LINE_PIXELS: csr_in.line_pixels = csr_data[12:0];
            CSR_FIRST_GLYPH: csr_in.first_glyph = csr_data[7:0];
            CSR_LAST_GLYPH:  csr_in.last_glyph  = csr_data[7:0];
            default:         csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.text_cols   <= RST_TEXT_COLS;
         csr_ff.text_rows   <= RST_TEXT_ROWS;
         csr_ff.line_pixels <= RST_LINE_PIXELS;
         csr_ff.first_glyph <= RST_FIRST_GLYPH;
         csr_ff.last_glyph  <= RST_LAST_GLYPH;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // hold the request word until the queue can take its results
   assign step      = req_vld_ff && room;
   assign req_stall = req_vld_ff && !room;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      req_vld_in = req_vld_ff;
      if (accept) req_vld_in = 1'b1;
      else if (step) req_vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) req_vld_ff <= 1'b0;
      else req_vld_ff <= req_vld_in;
   end

   always_ff @(posedge clock) begin
      if (accept) req_word_ff <= req_data;
   end

   tccc_cursor #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS),
      .TAB_STOP (TAB_STOP),
      .GLYPH_W  (GLYPH_W),
      .GLYPH_H  (GLYPH_H)
   ) u_cursor (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .req_word (req_word_ff),
      .csr      (csr_ff),
      .result   (result)
   );

   tccc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .result    (result),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
